@@ rtl/core/rde_pkg.sv @@
// Shared types, constants and constant functions of the Rayleigh distribution evaluator.
package rde_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned EXP_TERMS = 24;
  localparam logic [31:0] SIGMA_RESET = 32'd65536;
  localparam logic [0:0] REG_SIGMA = 1'b0;
  localparam logic [40:0] ONE_Q40 = {1'b1, 40'd0};
  localparam logic signed [47:0] G_MAX = {1'b0, {47{1'b1}}};
  localparam logic signed [47:0] G_MIN = {1'b1, 47'd0};
  localparam logic signed [63:0] ACC_MAX = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] ACC_MIN = {1'b1, 63'd0};

  // Right shift applied to a 128-bit product.
  typedef enum logic [1:0] {
    SH_25 = 2'd0,
    SH_40 = 2'd1,
    SH_48 = 2'd2
  } shift_sel_t;

  typedef struct packed {
    logic               neg;
    logic [31:0]        ax;
    logic [31:0]        s;
    logic signed [31:0] residual;
    logic               last;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } q_head_t;

  typedef struct packed {
    logic       start;
    logic [63:0] a;
    logic [63:0] b;
    shift_sel_t sh;
  } mul_req_t;

  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  // exp(-1) in Q40, built from the same truncated alternating series as the datapath.
  function automatic logic [40:0] exp_neg_one();
    logic [40:0]        term;
    logic signed [42:0] sum;
    logic               live;
    term = ONE_Q40;
    sum  = $signed({2'b00, ONE_Q40});
    live = 1'b1;
    for (int k = 1; k <= EXP_TERMS; k++) begin
      if (live) begin
        term = term / 41'(k);
        if (term == '0) begin
          live = 1'b0;
        end else if ((k % 2) == 1) begin
          sum = sum - $signed({2'b00, term});
        end else begin
          sum = sum + $signed({2'b00, term});
        end
      end
    end
    if (sum < 0) begin
      return '0;
    end else if (sum > $signed({2'b00, ONE_Q40})) begin
      return ONE_Q40;
    end
    return sum[40:0];
  endfunction

  localparam logic [40:0] EXP_NEG_ONE = exp_neg_one();

endpackage

@@ rtl/core/rde_front.sv @@
// Front end: accepts samples, classifies sign and scale, and queues them for the back end.
module rde_front #(
  parameter int unsigned DEPTH = rde_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic signed [31:0]  x_value,
  input  logic signed [31:0]  residual,
  input  logic                last,
  input  logic [31:0]         sigma,
  input  logic                pop,
  output rde_pkg::q_head_t    head
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  rde_pkg::item_t entries [DEPTH];
  rde_pkg::item_t cls;
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;
  logic           push;
  logic           take;

  // A negative sample is folded to its magnitude; a zero scale acts as one LSB.
  always_comb begin
    cls.neg      = x_value[31];
    cls.ax       = x_value[31] ? (~x_value + 32'd1) : x_value;
    cls.s        = (sigma == '0) ? 32'd1 : sigma;
    cls.residual = residual;
    cls.last     = last;
  end

  assign in_stall   = (count == CW'(DEPTH));
  assign push       = in_valid && !in_stall;
  assign head.valid = (count != '0);
  assign head.item  = entries[rd_ptr];
  assign take       = pop && head.valid;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (take) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !take) begin
        count <= count + 1'b1;
      end else if (take && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ rtl/core/rde_div.sv @@
// Radix-2 restoring divider, 64-bit dividend by 32-bit divisor, one quotient bit per cycle.
module rde_div (
  input  logic              clk,
  input  logic              rst,
  input  rde_pkg::div_req_t req,
  output logic              done,
  output logic [63:0]       quotient
);

  logic        busy;
  logic [5:0]  cnt;
  logic [63:0] work;
  logic [31:0] rem;
  logic [31:0] dvs;
  logic [32:0] rem_sh;
  logic        ge;
  logic [31:0] rem_next;

  always_comb begin
    rem_sh   = {rem, work[63]};
    ge       = rem_sh >= {1'b0, dvs};
    rem_next = ge ? 32'(rem_sh - {1'b0, dvs}) : rem_sh[31:0];
  end

  assign quotient = work;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= !req.start && busy && (cnt == 6'd63);
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        work <= req.dividend;
        rem  <= '0;
        dvs  <= req.divisor;
      end else if (busy) begin
        work <= {work[62:0], ge};
        rem  <= rem_next;
        cnt  <= cnt + 1'b1;
        if (cnt == 6'd63) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

@@ rtl/core/rde_mul.sv @@
// 64x64 multiplier over four 32x32 partial products, with a truncating, saturating shift.
module rde_mul (
  input  logic              clk,
  input  logic              rst,
  input  rde_pkg::mul_req_t req,
  output logic              done,
  output logic [63:0]       result
);

  logic                busy;
  logic [2:0]          cnt;
  logic [63:0]         a_r;
  logic [63:0]         b_r;
  rde_pkg::shift_sel_t sh_r;
  logic [63:0]         pp;
  logic [1:0]          pp_off;
  logic [127:0]        acc;
  logic [31:0]         a_part;
  logic [31:0]         b_part;
  logic [127:0]        pp_wide;
  logic [63:0]         fin;

  always_comb begin
    a_part = cnt[1] ? a_r[63:32] : a_r[31:0];
    b_part = cnt[0] ? b_r[63:32] : b_r[31:0];
    case (pp_off)
      2'd0:    pp_wide = {64'd0, pp};
      2'd1:    pp_wide = {32'd0, pp, 32'd0};
      default: pp_wide = {pp, 64'd0};
    endcase
    // Anything left above bit 63 after the shift saturates the result.
    case (sh_r)
      rde_pkg::SH_25: fin = (acc[127:89] != '0) ? '1 : acc[88:25];
      rde_pkg::SH_40: fin = (acc[127:104] != '0) ? '1 : acc[103:40];
      rde_pkg::SH_48: fin = (acc[127:112] != '0) ? '1 : acc[111:48];
      default:        fin = '1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= !req.start && busy && (cnt == 3'd5);
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
        a_r  <= req.a;
        b_r  <= req.b;
        sh_r <= req.sh;
        acc  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt <= 3'd3) begin
          pp     <= a_part * b_part;
          pp_off <= {1'b0, cnt[1]} + {1'b0, cnt[0]};
        end
        if ((cnt >= 3'd1) && (cnt <= 3'd4)) begin
          acc <= acc + pp_wide;
        end
        if (cnt == 3'd5) begin
          result <= fin;
          busy   <= 1'b0;
        end
      end
    end
  end

endmodule

@@ rtl/core/rde_back.sv @@
// Back end: sequences the shared divider and multiplier per sample, accumulates, and holds the result.
module rde_back (
  input  logic                    clk,
  input  logic                    rst,
  input  rde_pkg::q_head_t        head,
  output logic                    pop,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [31:0]      density,
  output logic [16:0]             cumulative,
  output logic signed [31:0]      cdf_slope,
  output logic signed [47:0]      gradient_sum,
  output logic                    run_end,
  output logic                    saturated
);

  typedef enum logic [14:0] {
    ST_IDLE = 15'h0001,
    ST_DIVU = 15'h0002,
    ST_SQ   = 15'h0004,
    ST_TMUL = 15'h0008,
    ST_TDIV = 15'h0010,
    ST_EXPE = 15'h0020,
    ST_POW  = 15'h0040,
    ST_PMUL = 15'h0080,
    ST_DIVV = 15'h0100,
    ST_PM   = 15'h0200,
    ST_SM   = 15'h0400,
    ST_ACC  = 15'h0800,
    ST_PROD = 15'h1000,
    ST_ADD  = 15'h2000,
    ST_OUT  = 15'h4000
  } state_t;

  state_t              state;
  rde_pkg::item_t      it;
  rde_pkg::mul_req_t   mul_req;
  rde_pkg::div_req_t   div_req;
  logic                mul_done;
  logic [63:0]         mul_result;
  logic                div_done;
  logic [63:0]         div_quot;

  logic [63:0]         u;
  logic [8:0]          n;
  logic [39:0]         f;
  logic signed [42:0]  sum;
  logic [4:0]          k;
  logic [40:0]         e;
  logic [8:0]          pw_i;
  logic [63:0]         p;
  logic [63:0]         smag;
  logic signed [31:0]  dens;
  logic signed [31:0]  slope;
  logic [16:0]         cum;
  logic                sat;
  logic signed [63:0]  prod;
  logic signed [63:0]  acc;

  logic [47:0]         dmag;
  logic signed [31:0]  dens_c;
  logic signed [31:0]  slope_c;
  logic                dsat;
  logic                ssat;
  logic [41:0]         cum_full;
  logic [17:0]         cum_sh;
  logic [16:0]         cum_c;
  logic [40:0]         e_clamp;
  logic signed [42:0]  term_s;
  logic signed [64:0]  sum65;
  logic                acc_ovf;
  logic signed [63:0]  acc_next;
  logic signed [48:0]  g49;
  logic signed [47:0]  g_c;
  logic                gsat;
  logic                out_free;

  rde_mul u_mul (
    .clk    (clk),
    .rst    (rst),
    .req    (mul_req),
    .done   (mul_done),
    .result (mul_result)
  );

  rde_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .done     (div_done),
    .quotient (div_quot)
  );

  assign pop      = (state == ST_IDLE) && head.valid;
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    dmag = p[63:16];
    dsat = 1'b0;
    if (it.neg) begin
      if (dmag > 48'h0000_8000_0000) begin
        dens_c = 32'sh8000_0000;
        dsat   = 1'b1;
      end else begin
        dens_c = ~dmag[31:0] + 32'd1;
      end
    end else if (dmag > 48'h0000_7FFF_FFFF) begin
      dens_c = 32'sh7FFF_FFFF;
      dsat   = 1'b1;
    end else begin
      dens_c = dmag[31:0];
    end

    ssat = smag > 64'h0000_0000_8000_0000;
    slope_c = ssat ? 32'sh8000_0000 : (~smag[31:0] + 32'd1);

    cum_full = 42'(rde_pkg::ONE_Q40) - 42'(e) + 42'(24'h80_0000);
    cum_sh   = cum_full[41:24];
    cum_c    = (cum_sh > 18'd65536) ? 17'd65536 : cum_sh[16:0];

    if (sum[42]) begin
      e_clamp = '0;
    end else if (sum > $signed({2'b00, rde_pkg::ONE_Q40})) begin
      e_clamp = rde_pkg::ONE_Q40;
    end else begin
      e_clamp = sum[40:0];
    end
    term_s = $signed({2'b00, div_quot[40:0]});

    sum65   = {acc[63], acc} + {prod[63], prod};
    acc_ovf = sum65[64] != sum65[63];
    if (acc_ovf) begin
      acc_next = sum65[64] ? rde_pkg::ACC_MIN : rde_pkg::ACC_MAX;
    end else begin
      acc_next = sum65[63:0];
    end

    // Floor division by 2^15 is an arithmetic shift; clamp to 48 bits.
    g49  = acc[63:15];
    gsat = g49[48] != g49[47];
    if (gsat) begin
      g_c = g49[48] ? rde_pkg::G_MIN : rde_pkg::G_MAX;
    end else begin
      g_c = g49[47:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      mul_req.start <= 1'b0;
      div_req.start <= 1'b0;
      out_valid     <= 1'b0;
      acc           <= '0;
    end else begin
      // A start lasts one cycle; no unit is relaunched the cycle after its start.
      if (mul_req.start) begin
        mul_req.start <= 1'b0;
      end
      if (div_req.start) begin
        div_req.start <= 1'b0;
      end
      if (out_valid && !out_stall && (state != ST_OUT)) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (head.valid) begin
            it      <= head.item;
            sat     <= 1'b0;
            div_req <= '{start: 1'b1, dividend: {head.item.ax, 32'd0},
                         divisor: head.item.s};
            state   <= ST_DIVU;
          end
        end
        ST_DIVU: begin
          if (div_done) begin
            u <= div_quot;
            if (div_quot[63:37] != '0) begin
              // |x| at or beyond 32 sigma: the exponential term is zero.
              e     <= '0;
              p     <= '0;
              smag  <= '0;
              state <= ST_ACC;
            end else begin
              mul_req <= '{start: 1'b1, a: div_quot, b: div_quot, sh: rde_pkg::SH_25};
              state   <= ST_SQ;
            end
          end
        end
        ST_SQ: begin
          if (mul_done) begin
            n       <= mul_result[48:40];
            f       <= mul_result[39:0];
            sum     <= $signed({2'b00, rde_pkg::ONE_Q40});
            k       <= 5'd1;
            mul_req <= '{start: 1'b1, a: 64'(rde_pkg::ONE_Q40),
                         b: {24'd0, mul_result[39:0]}, sh: rde_pkg::SH_40};
            state   <= ST_TMUL;
          end
        end
        ST_TMUL: begin
          if (mul_done) begin
            div_req <= '{start: 1'b1, dividend: mul_result, divisor: 32'(k)};
            state   <= ST_TDIV;
          end
        end
        ST_TDIV: begin
          if (div_done) begin
            if (div_quot == '0) begin
              state <= ST_EXPE;
            end else begin
              sum <= k[0] ? (sum - term_s) : (sum + term_s);
              if (k == 5'(rde_pkg::EXP_TERMS)) begin
                state <= ST_EXPE;
              end else begin
                k       <= k + 1'b1;
                mul_req <= '{start: 1'b1, a: div_quot, b: {24'd0, f},
                             sh: rde_pkg::SH_40};
                state   <= ST_TMUL;
              end
            end
          end
        end
        ST_EXPE: begin
          e     <= e_clamp;
          pw_i  <= '0;
          state <= ST_POW;
        end
        ST_POW: begin
          if ((pw_i < n) && (e != '0)) begin
            mul_req <= '{start: 1'b1, a: 64'(e), b: 64'(rde_pkg::EXP_NEG_ONE),
                         sh: rde_pkg::SH_40};
            state   <= ST_PMUL;
          end else begin
            div_req <= '{start: 1'b1, dividend: {u[47:0], 16'd0}, divisor: it.s};
            state   <= ST_DIVV;
          end
        end
        ST_PMUL: begin
          if (mul_done) begin
            e     <= mul_result[40:0];
            pw_i  <= pw_i + 1'b1;
            state <= ST_POW;
          end
        end
        ST_DIVV: begin
          if (div_done) begin
            mul_req <= '{start: 1'b1, a: div_quot, b: 64'(e), sh: rde_pkg::SH_40};
            state   <= ST_PM;
          end
        end
        ST_PM: begin
          if (mul_done) begin
            p       <= mul_result;
            mul_req <= '{start: 1'b1, a: u, b: mul_result, sh: rde_pkg::SH_48};
            state   <= ST_SM;
          end
        end
        ST_SM: begin
          if (mul_done) begin
            smag  <= mul_result;
            state <= ST_ACC;
          end
        end
        ST_ACC: begin
          dens  <= dens_c;
          slope <= slope_c;
          cum   <= cum_c;
          sat   <= sat | dsat | ssat;
          state <= ST_PROD;
        end
        ST_PROD: begin
          prod  <= it.residual * slope;
          state <= ST_ADD;
        end
        ST_ADD: begin
          acc   <= acc_next;
          sat   <= sat | acc_ovf;
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (out_free) begin
            out_valid    <= 1'b1;
            density      <= dens;
            cumulative   <= cum;
            cdf_slope    <= slope;
            gradient_sum <= it.last ? g_c : '0;
            run_end      <= it.last;
            saturated    <= sat | (it.last & gsat);
            if (it.last) begin
              acc <= '0;
            end
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

@@ rtl/core/rayleigh_distribution_evaluator_core.sv @@
// Top level of the Rayleigh distribution evaluator: register port, front end and back end.
//
//   Channel   Direction  Handshake            Payload
//   -------   ---------  -------------------  ------------------------------------------
//   config    in         psel/penable/pready  paddr, pwdata, prdata (sigma at 0)
//   samples   in         in_valid/in_stall    x_value, residual, last
//   results   out        out_valid/out_stall  density, cumulative, cdf_slope,
//                                             gradient_sum, run_end, saturated
//
// The work per item grows with J (1 to 24), the number of exp(-f) series terms formed,
// up to and including the first zero term, and with N, the number of exp(-1) products:
// at most floor(x^2 / (2 sigma^2)), ending early once the running product is zero.
// A sample at or beyond 32 sigma goes straight from the division to the accumulation.
// Divisions run on the shared radix-2 divider and products on the four-pass 32x32 multiplier.
// Reset is synchronous: it sets sigma to 1.0, clears the accumulator, empties the queue.
// Samples keep flowing into the queue while the back end works or a result waits, until
// the queue is full; a stalled result holds the back end, once its next result is ready, until the stall ends.
//
// The front end folds each sample into sign and magnitude, replaces a zero sigma by one
// LSB, and pushes the item into a short queue. The back end pops one item at a time and
// walks through the exponential evaluation: |x|/sigma by division, the square by
// multiplication, the Taylor series for the fractional part, then one multiplication by
// exp(-1) for every whole unit of the exponent. After the density and slope are formed
// and clamped, residual times slope is added into a saturating 64-bit accumulator; on a
// sample marked last the run total is reported and the accumulator cleared.
module rayleigh_distribution_evaluator_core #(
  parameter int unsigned QUEUE_DEPTH = rde_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] x_value,
  input  logic signed [31:0] residual,
  input  logic               last,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] density,
  output logic [16:0]        cumulative,
  output logic signed [31:0] cdf_slope,
  output logic signed [47:0] gradient_sum,
  output logic               run_end,
  output logic               saturated
);

  logic             [31:0] sigma;
  rde_pkg::q_head_t        head;
  logic                    pop;

  // The register port has a single register, decoded from paddr[2] alone; writes with paddr[2] set are dropped.
  assign pready = 1'b1;
  assign prdata = (paddr[2:2] == rde_pkg::REG_SIGMA) ? sigma : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      sigma <= rde_pkg::SIGMA_RESET;
    end else if (psel && penable && pwrite && pready &&
                 (paddr[2:2] == rde_pkg::REG_SIGMA)) begin
      sigma <= pwdata;
    end
  end

  rde_front #(
    .DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .x_value  (x_value),
    .residual (residual),
    .last     (last),
    .sigma    (sigma),
    .pop      (pop),
    .head     (head)
  );

  rde_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .density      (density),
    .cumulative   (cumulative),
    .cdf_slope    (cdf_slope),
    .gradient_sum (gradient_sum),
    .run_end      (run_end),
    .saturated    (saturated)
  );

  // A run total appears only on the item that closes a run.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !run_end |-> gradient_sum == '0)
    else $error("gradient_sum nonzero outside a run end");

  // The cumulative value never exceeds one.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> cumulative <= 17'd65536)
    else $error("cumulative above one");

  // The derivative by sigma is never positive.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (cdf_slope[31] || (cdf_slope == '0)))
    else $error("cdf_slope positive");

endmodule
